[design/wio_pkg.sv]
// Package for the wavetable oscillator: field widths, register indexes,
// item kinds and the default values of the top-level parameters.
// Depends on nothing; the oscillator top level refers to it by scoped names.
package wio_pkg;

    localparam int DEF_TABLE_DEPTH  = 4096;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_FRAC_BITS    = 16;

    localparam int PHASE_BITS  = 29;
    localparam int STEP_BITS   = 28;
    localparam int LENGTH_BITS = 13;
    localparam int ADDR_BITS   = 12;
    localparam int CFG_DATA_BITS  = STEP_BITS;
    localparam int CFG_INDEX_BITS = 1;

    // Width used for comparing phase integer parts, lengths and addresses.
    localparam int CMP_BITS = 32;

    typedef logic [CFG_INDEX_BITS-1:0] t_cfg_index;

    localparam t_cfg_index CFG_PHASE_STEP   = 1'b0;
    localparam t_cfg_index CFG_TABLE_LENGTH = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [STEP_BITS-1:0]   RESET_PHASE_STEP   = STEP_BITS'(65536);
    localparam logic [LENGTH_BITS-1:0] RESET_TABLE_LENGTH = LENGTH_BITS'(4096);

endpackage

[design/wavetable_interpolating_oscillator_unit.sv]
// Top level of the wavetable oscillator: table memory, phase accumulator,
// interpolation pipeline and output register.
// Depends on wio_pkg for widths, codes and parameter defaults.
//
// Use: the input channel (i_in_valid / o_in_stall) carries one beat per item.
// A beat with i_kind at load writes i_entry_value into the table entry at
// i_entry_address and gives no sample. A beat with i_kind at tick gives one
// interpolated sample on the output channel (o_out_valid / i_out_stall).
// The configuration port (i_cfg_valid / o_cfg_ready) is always ready and
// writes the phase step or the table length; the user must write it only
// when idle; the block does not check. Ticks pass the stage-one, product
// and output registers; one item per cycle is taken while o_in_stall is
// low. The table is one memory with one write port and two read ports, so
// both neighbouring entries are read, and the phase is updated, in the
// cycle the tick is taken. When the receiver stalls, the two stages fill
// up behind the output register, and o_in_stall rises only once the stage
// after the memory read is occupied and cannot move on. Reset clears the
// phase and valid bits and resets the configuration; the table content is
// not cleared and must be written before it is read.
module wavetable_interpolating_oscillator_unit #(
    parameter int TABLE_DEPTH  = wio_pkg::DEF_TABLE_DEPTH,
    parameter int SAMPLE_WIDTH = wio_pkg::DEF_SAMPLE_WIDTH,
    parameter int FRAC_BITS    = wio_pkg::DEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_kind,
    input  logic [wio_pkg::ADDR_BITS-1:0]     i_entry_address,
    input  logic signed [SAMPLE_WIDTH-1:0]    i_entry_value,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    o_sample_out,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wio_pkg::t_cfg_index               i_cfg_index,
    input  logic [wio_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int PB   = wio_pkg::PHASE_BITS;
    localparam int CW   = wio_pkg::CMP_BITS;
    localparam int PW   = SAMPLE_WIDTH + FRAC_BITS + 2;
    localparam int QW   = PW + 1 - FRAC_BITS;

    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
    localparam logic [PW:0]   HALF    = (PW+1)'(1) << (FRAC_BITS - 1);

    // Configuration registers.
    logic [wio_pkg::STEP_BITS-1:0]   r_phase_step;
    logic [wio_pkg::LENGTH_BITS-1:0] r_table_length;

    // Phase accumulator.
    logic [PB-1:0] r_phase;
    logic [PB-1:0] n_phase;

    // Table memory.
    logic signed [SAMPLE_WIDTH-1:0] r_wave_mem [TABLE_DEPTH];

    // Stage one: entries read, weights.
    logic                           r_v1;
    logic signed [SAMPLE_WIDTH-1:0] r_a;
    logic signed [SAMPLE_WIDTH-1:0] r_b;
    logic [FRAC_BITS-1:0]           r_frac;
    logic [FRAC_BITS:0]             r_wf;

    // Stage two: weighted products.
    logic                  r_v2;
    logic signed [PW-1:0]  r_pa;
    logic signed [PW-1:0]  r_pb;

    // Output register.
    logic                           r_out_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_sample;

    logic en1, en2, en3;
    logic accept, tick, load;

    logic [CW-1:0]    len_c;
    logic [CW-1:0]    eff_len;
    logic [CW-1:0]    int_c;
    logic [CW-1:0]    wj_c;
    logic [PB-1:0]    ph0;
    logic [AW-1:0]    wi;
    logic [AW-1:0]    wj;
    logic [FRAC_BITS-1:0] frac0;
    logic [FRAC_BITS:0]   wf0;
    logic             addr_ok;

    logic signed [PW:0]    acc;
    logic signed [QW-1:0]  q;
    logic                  sat;
    logic signed [SAMPLE_WIDTH-1:0] n_sample;

    // Each stage moves on when the one after it is empty or moving on.
    assign en3 = !r_out_valid || !i_out_stall;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_stall  = !en1;
    assign accept      = i_in_valid && en1;
    assign tick        = accept && (i_kind == wio_pkg::KIND_TICK);
    assign load        = accept && (i_kind == wio_pkg::KIND_LOAD);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample;

    // Phase wrap, entry addresses and weights for the tick being taken.
    always_comb begin
        len_c   = CW'(r_table_length);
        eff_len = (len_c > DEPTH_C) ? DEPTH_C : len_c;
        if (eff_len == '0) begin
            eff_len = CW'(1);
        end
        int_c = CW'(r_phase[PB-1:FRAC_BITS]);
        ph0   = (int_c >= eff_len) ? '0 : r_phase;
        int_c = CW'(ph0[PB-1:FRAC_BITS]);
        wj_c  = int_c + CW'(1);
        if (wj_c >= eff_len) begin
            wj_c = '0;
        end
        wi      = int_c[AW-1:0];
        wj      = wj_c[AW-1:0];
        frac0   = ph0[FRAC_BITS-1:0];
        wf0     = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac0};
        n_phase = ph0 + PB'(r_phase_step);
        addr_ok = CW'(i_entry_address) < DEPTH_C;
    end

    // Blend, round half up, saturate.
    always_comb begin
        acc = {r_pa[PW-1], r_pa} + {r_pb[PW-1], r_pb} + $signed(HALF);
        q   = acc[PW:FRAC_BITS];
        sat = (q[QW-1:SAMPLE_WIDTH-1] != {(QW-SAMPLE_WIDTH+1){q[QW-1]}});
        if (sat) begin
            n_sample = q[QW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                               : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else begin
            n_sample = q[SAMPLE_WIDTH-1:0];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= wio_pkg::RESET_PHASE_STEP;
            r_table_length <= wio_pkg::RESET_TABLE_LENGTH;
            r_phase        <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wio_pkg::CFG_PHASE_STEP:   r_phase_step <= i_cfg_data;
                    wio_pkg::CFG_TABLE_LENGTH:
                        r_table_length <= i_cfg_data[wio_pkg::LENGTH_BITS-1:0];
                    default: ;
                endcase
            end
            if (tick) begin
                r_phase <= n_phase;
            end
            if (en1) begin
                r_v1 <= tick;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_out_valid <= r_v2;
            end
        end
    end

    // Table memory: one write port, two registered read ports. A load and a
    // tick are never taken in the same cycle, so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (load && addr_ok) begin
            r_wave_mem[AW'(i_entry_address)] <= i_entry_value;
        end
        if (en1) begin
            r_a    <= r_wave_mem[wi];
            r_b    <= r_wave_mem[wj];
            r_frac <= frac0;
            r_wf   <= wf0;
        end
    end

    // Payload of the product and output stages.
    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pa <= $signed({{(FRAC_BITS+2){r_a[SAMPLE_WIDTH-1]}}, r_a})
                  * $signed({{(SAMPLE_WIDTH+1){1'b0}}, r_wf});
            r_pb <= $signed({{(FRAC_BITS+2){r_b[SAMPLE_WIDTH-1]}}, r_b})
                  * $signed({{(SAMPLE_WIDTH+2){1'b0}}, r_frac});
        end
        if (en3) begin
            r_sample <= n_sample;
        end
    end

endmodule
